// ----- rtl/core/hsq_pkg.sv -----
// ----------------------------------------------------------------------------
// hsq_pkg
// Shared widths, defaults, vertex record and helpers of the terrain height
// query block.
// ----------------------------------------------------------------------------
package hsq_pkg;

  localparam int COORD_W          = 32;
  localparam int INDEX_W          = 14;
  localparam int STORE_DEPTH      = 16384;
  localparam int Q14_W            = 16;
  localparam int COS_W            = 15;
  localparam int DIV_W            = 64;
  localparam int RECIP_SHIFT      = 22;
  localparam int GRID_WIDTH_DEF   = 128;
  localparam int GRID_DEPTH_DEF   = 128;
  localparam int CELL_SPACING_DEF = 1;

  localparam logic [COS_W-1:0] COS_RESET = 15'd14746;

  // request actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

  // clamp a 33-bit difference into signed 32 bits
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [COORD_W:0] d);
    logic signed [COORD_W-1:0] r;
    if (d[COORD_W] != d[COORD_W-1]) begin
      r = d[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      r = d[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/hsq_req_if.sv -----
// ----------------------------------------------------------------------------
// hsq_req_if
// Request channel: vertex writes and height queries.
// ----------------------------------------------------------------------------
interface hsq_req_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   action;
  logic        [hsq_pkg::INDEX_W-1:0]     vertex_index;
  logic signed [hsq_pkg::COORD_W-1:0]     vertex_x;
  logic signed [hsq_pkg::COORD_W-1:0]     vertex_y;
  logic signed [hsq_pkg::COORD_W-1:0]     vertex_z;
  logic signed [hsq_pkg::COORD_W-1:0]     pos_x;
  logic signed [hsq_pkg::COORD_W-1:0]     pos_z;

  modport source (output valid, action, vertex_index, vertex_x, vertex_y, vertex_z,
                  pos_x, pos_z, input ready);
  modport sink   (input valid, action, vertex_index, vertex_x, vertex_y, vertex_z,
                  pos_x, pos_z, output ready);
endinterface

// ----- rtl/core/hsq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// hsq_rsp_if
// Result channel: height, slope flags and unit normal.
// ----------------------------------------------------------------------------
interface hsq_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               blocked;
  logic                               out_of_bounds;
  logic signed [hsq_pkg::COORD_W-1:0] height;
  logic signed [hsq_pkg::Q14_W-1:0]   normal_x;
  logic signed [hsq_pkg::Q14_W-1:0]   normal_y;
  logic signed [hsq_pkg::Q14_W-1:0]   normal_z;

  modport source (output valid, blocked, out_of_bounds, height, normal_x, normal_y,
                  normal_z, input ready);
  modport sink   (input valid, blocked, out_of_bounds, height, normal_x, normal_y,
                  normal_z, output ready);
endinterface

// ----- rtl/core/hsq_ram.sv -----
// ----------------------------------------------------------------------------
// hsq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hsq_ram #(
  parameter int WIDTH = 3 * hsq_pkg::COORD_W,
  parameter int DEPTH = hsq_pkg::STORE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/hsq_div.sv -----
// ----------------------------------------------------------------------------
// hsq_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hsq_div #(
  parameter int W = hsq_pkg::DIV_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  dvd;
  logic [W-1:0]  dsr;
  logic [W-1:0]  rem;
  logic [W:0]    rem_sh;
  logic          ge;

  assign rem_sh   = {rem, dvd[W-1]};
  assign ge       = rem_sh >= {1'b0, dsr};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        // quotient bits shift in where the dividend bits leave
        rem <= ge ? W'(rem_sh - {1'b0, dsr}) : rem_sh[W-1:0];
        dvd <= {dvd[W-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");
  a_done_once: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held");
  a_zero_cnt: assert property (@(posedge clk) disable iff (rst) done |-> cnt == '0)
    else $error("divider finished early");

endmodule

// ----- rtl/core/heightmap_slope_height_query.sv -----
// ----------------------------------------------------------------------------
// heightmap_slope_height_query
// Terrain vertex grid with slope-limited height queries.
// ----------------------------------------------------------------------------
// Channels: req (valid/ready) carries either a vertex write (action 0) or a
// height query (action 1); rsp (valid/ready) returns one beat per query and
// none per write. cfg_we/cfg_wdata load the climb cosine (unsigned Q1.14).
// A write is accepted only while no query is in progress. A query beat
// first locates its cell; an out-of-range cell goes straight to the output
// register. Otherwise three vertices are read, the cross product is formed,
// shrunk by the normal reduction shift loop and taken through 32 square-root
// steps; a degenerate normal ends there. Three passes of the serial divider
// give the unit normal, the slope check ends a blocked query, and one more
// divider pass gives the height of a climbable one.
// Vertices sit in one 96-bit wide RAM; each in-range query reads three of them.
// One item is worked on at a time; a new beat is taken as soon as the
// previous result sits in the output register, even while rsp is stalled.
// Reset sets the climb cosine to 0.9 and empties the pipeline; the vertex
// RAM is not cleared and must be written before it is queried.
// ----------------------------------------------------------------------------
module heightmap_slope_height_query #(
  parameter int GRID_WIDTH   = hsq_pkg::GRID_WIDTH_DEF,
  parameter int GRID_DEPTH   = hsq_pkg::GRID_DEPTH_DEF,
  parameter int CELL_SPACING = hsq_pkg::CELL_SPACING_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [hsq_pkg::COS_W-1:0] cfg_wdata,
  hsq_req_if.sink                   req,
  hsq_rsp_if.source                 rsp
);

  localparam int AW    = hsq_pkg::INDEX_W;
  localparam int CW    = hsq_pkg::COORD_W;
  localparam int QW    = hsq_pkg::Q14_W;
  localparam int DW    = hsq_pkg::DIV_W;
  localparam int RSH   = hsq_pkg::RECIP_SHIFT;
  localparam int RECIP = (2**hsq_pkg::RECIP_SHIFT + CELL_SPACING - 1) / CELL_SPACING;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_ADDR   = 16'h0002,
    S_RDA    = 16'h0004,
    S_RD2    = 16'h0008,
    S_RD3    = 16'h0010,
    S_CROSS  = 16'h0020,
    S_MAG    = 16'h0040,
    S_RED    = 16'h0080,
    S_SQ     = 16'h0100,
    S_SQRT   = 16'h0200,
    S_QDIV   = 16'h0400,
    S_CHECK  = 16'h0800,
    S_HMUL   = 16'h1000,
    S_HSTART = 16'h2000,
    S_HDIV   = 16'h4000,
    S_OUT    = 16'h8000
  } state_t;

  state_t state;
  logic [2:0] k;
  logic [1:0] qj;
  logic       div_started;
  logic [hsq_pkg::COS_W-1:0] climb;

  logic signed [CW-1:0] px, pz, ax, ay, az, dx, dz;
  logic signed [CW-1:0] u [3];
  logic signed [CW-1:0] w [3];
  logic [AW-1:0]        idx;
  logic                 upper;
  logic signed [64:0]   nfull [3];
  logic [63:0]          mag [3];
  logic                 neg [3];
  logic [63:0]          sumsq, sq_v, sq_res, sq_bit;
  logic [30:0]          len;
  logic signed [QW-1:0] qv [3];
  logic signed [63:0]   num;
  logic                 r_blocked, r_oob;
  logic signed [CW-1:0] r_height;

  logic                 o_valid, o_blocked, o_oob;
  logic signed [CW-1:0] o_height;
  logic signed [QW-1:0] o_nx, o_ny, o_nz;

  // ---------------------------------------------------------------- vertex RAM
  hsq_pkg::vertex_t rv;
  logic [3*CW-1:0]  ram_rdata;
  logic [AW-1:0]    raddr;
  logic             ram_we;

  assign ram_we = req.valid && req.ready && (req.action == hsq_pkg::ACT_WRITE);

  hsq_ram #(.WIDTH(3 * CW), .DEPTH(hsq_pkg::STORE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req.vertex_index),
    .wdata ({req.vertex_x, req.vertex_y, req.vertex_z}),
    .raddr (raddr),
    .rdata (ram_rdata)
  );
  assign rv = hsq_pkg::vertex_t'(ram_rdata);

  // ----------------------------------------------------------- cell location
  logic [14:0]  colv, rowv;
  logic [37:0]  col_prod, row_prod;
  logic [15:0]  col, row;
  logic [31:0]  idx_full;
  logic [AW-1:0] idx_c;
  logic         oob_c;

  assign colv     = px[30:16];
  assign rowv     = pz[30:16];
  // divide by the cell spacing through its reciprocal
  assign col_prod = 38'(colv) * 38'(RECIP);
  assign row_prod = 38'(rowv) * 38'(RECIP);
  assign col      = col_prod[RSH+15:RSH];
  assign row      = row_prod[RSH+15:RSH];
  assign idx_full = 32'(row) * 32'(GRID_WIDTH) + 32'(col);
  assign idx_c    = idx_full[AW-1:0];
  assign oob_c    = px[CW-1] || pz[CW-1] || (col >= 16'(GRID_WIDTH - 1)) ||
                    (row >= 16'(GRID_DEPTH - 1));

  // triangle choice against the corner vertex just read
  logic signed [CW:0] lhs_c, rhs_c;
  logic               upper_c;
  assign lhs_c   = {px[CW-1], px} - {rv.x[CW-1], rv.x};
  assign rhs_c   = {rv.z[CW-1], rv.z} - {pz[CW-1], pz};
  assign upper_c = lhs_c > rhs_c;

  always_comb begin
    unique case (state)
      S_ADDR:  raddr = idx_c + AW'(GRID_WIDTH);
      S_RDA:   raddr = upper_c ? idx + AW'(GRID_WIDTH) + AW'(1) : idx + AW'(1);
      S_RD2:   raddr = upper ? idx + AW'(1) : idx;
      default: raddr = idx;
    endcase
  end

  // ------------------------------------------------------ shared multiplier
  logic signed [CW-1:0] mul_a, mul_b;
  logic signed [63:0]   prod;
  logic signed [CW-1:0] sn0, sn2, sq0, sq1, sq2;

  assign sn0 = neg[0] ? -$signed({2'b0, mag[0][29:0]}) : $signed({2'b0, mag[0][29:0]});
  assign sn2 = neg[2] ? -$signed({2'b0, mag[2][29:0]}) : $signed({2'b0, mag[2][29:0]});
  assign sq0 = $signed({2'b0, mag[0][29:0]});
  assign sq1 = $signed({2'b0, mag[1][29:0]});
  assign sq2 = $signed({2'b0, mag[2][29:0]});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_CROSS) begin
      case (k)
        3'd0:    begin mul_a = u[1]; mul_b = w[2]; end
        3'd1:    begin mul_a = u[2]; mul_b = w[1]; end
        3'd2:    begin mul_a = u[2]; mul_b = w[0]; end
        3'd3:    begin mul_a = u[0]; mul_b = w[2]; end
        3'd4:    begin mul_a = u[0]; mul_b = w[1]; end
        3'd5:    begin mul_a = u[1]; mul_b = w[0]; end
        default: begin mul_a = '0;   mul_b = '0;   end
      endcase
    end else if (state == S_SQ) begin
      case (k)
        3'd0:    begin mul_a = sq0; mul_b = sq0; end
        3'd1:    begin mul_a = sq1; mul_b = sq1; end
        3'd2:    begin mul_a = sq2; mul_b = sq2; end
        default: begin mul_a = '0;  mul_b = '0;  end
      endcase
    end else if (state == S_HMUL) begin
      case (k)
        3'd0:    begin mul_a = sn0; mul_b = dx; end
        3'd1:    begin mul_a = sn2; mul_b = dz; end
        default: begin mul_a = '0;  mul_b = '0; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // ------------------------------------------------------- square-root step
  logic [63:0] sq_try, sq_res_n, sq_v_n;
  logic        sq_ge;
  assign sq_try   = sq_res + sq_bit;
  assign sq_ge    = sq_v >= sq_try;
  assign sq_res_n = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;
  assign sq_v_n   = sq_ge ? sq_v - sq_try : sq_v;

  // ----------------------------------------------------------------- divider
  logic          div_start, div_done;
  logic [DW-1:0] div_dvd, div_dsr, div_quo;
  logic [29:0]   qmag;
  logic [63:0]   num_mag;
  logic [15:0]   qbits;

  always_comb begin
    case (qj)
      2'd0:    qmag = mag[0][29:0];
      2'd1:    qmag = mag[1][29:0];
      default: qmag = mag[2][29:0];
    endcase
  end

  assign num_mag   = num[63] ? 64'(-num) : 64'(num);
  assign div_start = (state == S_HSTART) || (state == S_QDIV && !div_started);
  assign div_dvd   = (state == S_HSTART) ? num_mag
                                         : DW'({qmag, 14'b0}) + DW'(len >> 1);
  assign div_dsr   = (state == S_HSTART) ? DW'(mag[1]) : DW'(len);
  assign qbits     = div_quo[15:0];

  hsq_div #(.W(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_quo)
  );

  // height = A.y + signed quotient + 1.0, clamped to 32 bits
  logic signed [65:0] hq, hsum;
  logic signed [CW-1:0] h_sat;
  assign hq    = (num[63] ^ neg[1]) ? -$signed({2'b0, div_quo}) : $signed({2'b0, div_quo});
  assign hsum  = 66'(ay) + hq + 66'sd65536;
  assign h_sat = (hsum > 66'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                 (hsum < -66'sh0_8000_0000) ? 32'sh8000_0000 : hsum[CW-1:0];

  logic blocked_c;
  assign blocked_c = (mag[1] == '0) || ($signed(qv[1]) < $signed({1'b0, climb}));

  // -------------------------------------------------------------- sequencer
  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      k           <= '0;
      qj          <= '0;
      div_started <= 1'b0;
      climb       <= hsq_pkg::COS_RESET;
      o_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        climb <= cfg_wdata;
      end
      // a beat loaded in S_OUT keeps the flag set
      if (o_valid && rsp.ready && state != S_OUT) begin
        o_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid && req.action == hsq_pkg::ACT_QUERY) begin
            px    <= req.pos_x;
            pz    <= req.pos_z;
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          idx       <= idx_c;
          r_oob     <= oob_c;
          r_blocked <= 1'b0;
          r_height  <= '0;
          qv[0]     <= '0;
          qv[1]     <= '0;
          qv[2]     <= '0;
          state     <= oob_c ? S_OUT : S_RDA;
        end
        S_RDA: begin
          ax    <= rv.x;
          ay    <= rv.y;
          az    <= rv.z;
          upper <= upper_c;
          dx    <= hsq_pkg::sat32(lhs_c);
          dz    <= hsq_pkg::sat32({pz[CW-1], pz} - {rv.z[CW-1], rv.z});
          state <= S_RD2;
        end
        S_RD2: begin
          u[0]  <= hsq_pkg::sat32({rv.x[CW-1], rv.x} - {ax[CW-1], ax});
          u[1]  <= hsq_pkg::sat32({rv.y[CW-1], rv.y} - {ay[CW-1], ay});
          u[2]  <= hsq_pkg::sat32({rv.z[CW-1], rv.z} - {az[CW-1], az});
          state <= S_RD3;
        end
        S_RD3: begin
          w[0]  <= hsq_pkg::sat32({rv.x[CW-1], rv.x} - {ax[CW-1], ax});
          w[1]  <= hsq_pkg::sat32({rv.y[CW-1], rv.y} - {ay[CW-1], ay});
          w[2]  <= hsq_pkg::sat32({rv.z[CW-1], rv.z} - {az[CW-1], az});
          k     <= '0;
          state <= S_CROSS;
        end
        S_CROSS: begin
          // product issued in the previous cycle lands here
          k <= k + 3'd1;
          case (k)
            3'd1:    nfull[0] <= 65'(prod);
            3'd2:    nfull[0] <= nfull[0] - 65'(prod);
            3'd3:    nfull[1] <= 65'(prod);
            3'd4:    nfull[1] <= nfull[1] - 65'(prod);
            3'd5:    nfull[2] <= 65'(prod);
            3'd6:    nfull[2] <= nfull[2] - 65'(prod);
            default: ;
          endcase
          if (k == 3'd6) begin
            state <= S_MAG;
          end
        end
        S_MAG: begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= nfull[i][64];
            mag[i] <= nfull[i][64] ? 64'(-nfull[i]) : nfull[i][63:0];
          end
          state <= S_RED;
        end
        S_RED: begin
          // halve all components until the largest fits in 30 bits
          if ((mag[0][63:30] | mag[1][63:30] | mag[2][63:30]) != '0) begin
            mag[0] <= mag[0] >> 1;
            mag[1] <= mag[1] >> 1;
            mag[2] <= mag[2] >> 1;
          end else begin
            sumsq <= '0;
            k     <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          k <= k + 3'd1;
          if (k != 3'd0) begin
            sumsq <= sumsq + 64'(prod);
          end
          if (k == 3'd3) begin
            sq_v   <= sumsq + 64'(prod);
            sq_res <= '0;
            sq_bit <= 64'd1 << 62;
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          sq_v   <= sq_v_n;
          sq_res <= sq_res_n;
          sq_bit <= sq_bit >> 2;
          if (sq_bit == 64'd1) begin
            len <= sq_res_n[30:0];
            if (sq_res_n == '0) begin
              r_blocked <= 1'b1;
              state     <= S_OUT;
            end else begin
              qj          <= '0;
              div_started <= 1'b0;
              state       <= S_QDIV;
            end
          end
        end
        S_QDIV: begin
          if (div_done) begin
            case (qj)
              2'd0:    qv[0] <= neg[0] ? -$signed(qbits) : $signed(qbits);
              2'd1:    qv[1] <= neg[1] ? -$signed(qbits) : $signed(qbits);
              default: qv[2] <= neg[2] ? -$signed(qbits) : $signed(qbits);
            endcase
            div_started <= 1'b0;
            qj          <= qj + 2'd1;
            if (qj == 2'd2) begin
              state <= S_CHECK;
            end
          end else begin
            div_started <= 1'b1;
          end
        end
        S_CHECK: begin
          if (blocked_c) begin
            r_blocked <= 1'b1;
            state     <= S_OUT;
          end else begin
            k     <= '0;
            state <= S_HMUL;
          end
        end
        S_HMUL: begin
          k <= k + 3'd1;
          if (k == 3'd1) begin
            num <= -prod;
          end
          if (k == 3'd2) begin
            num   <= num - prod;
            state <= S_HSTART;
          end
        end
        S_HSTART: begin
          state <= S_HDIV;
        end
        S_HDIV: begin
          if (div_done) begin
            r_height <= h_sat;
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (!o_valid || rsp.ready) begin
            o_valid   <= 1'b1;
            o_blocked <= r_blocked;
            o_oob     <= r_oob;
            o_height  <= r_height;
            o_nx      <= qv[0];
            o_ny      <= qv[1];
            o_nz      <= qv[2];
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid         = o_valid;
  assign rsp.blocked       = o_blocked;
  assign rsp.out_of_bounds = o_oob;
  assign rsp.height        = o_height;
  assign rsp.normal_x      = o_nx;
  assign rsp.normal_y      = o_ny;
  assign rsp.normal_z      = o_nz;

  // -------------------------------------------------------------- assertions
  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
      (state == S_OUT && (!o_valid || rsp.ready)) |=> (o_valid && state == S_IDLE))
    else $error("result beat not loaded");
  a_reduced: assert property (@(posedge clk) disable iff (rst)
      state == S_SQ |-> ((mag[0][63:30] | mag[1][63:30] | mag[2][63:30]) == '0))
    else $error("normal not reduced below 2^30");
  a_len_nz: assert property (@(posedge clk) disable iff (rst)
      state == S_QDIV |-> len != '0)
    else $error("normal divided by zero length");
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
      ram_we |-> state == S_IDLE)
    else $error("vertex write during a query");
  a_oob_clean: assert property (@(posedge clk) disable iff (rst)
      (o_valid && o_oob) |-> (!o_blocked && o_height == '0 && o_ny == '0))
    else $error("out-of-bounds beat carries data");

endmodule
